@@ rtl/sfsx_pkg.sv @@
`default_nettype none

package sfsx_pkg;

  // Frame geometry.
  localparam int FRAME_BYTES   = 24;
  localparam int RAW_WORDS     = (FRAME_BYTES - 4) / 2;
  localparam int PAYLOAD_WORDS = (RAW_WORDS > 10) ? 10 : RAW_WORDS;

  // Field and counter widths.
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = $clog2(FRAME_BYTES + 1);
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_MARKER  = 2'd2;

  // Reset values of the markers.
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd83;
  localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd10;
  localparam logic [BYTE_W-1:0] TAIL_MARKER_RST  = 8'd13;

  // Result status codes.
  localparam logic STATUS_GOOD = 1'b0;
  localparam logic STATUS_BAD  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [PAYLOAD_WORDS-1:0] payload_t;

  // Capture event handed from the window to the emitter.
  typedef struct packed {
    logic fire;
    logic good;
  } capture_t;

endpackage

`default_nettype wire

@@ rtl/sfsx_cell.sv @@
`default_nettype none

module sfsx_cell (
  input  wire                 clk,
  input  wire                 shift_en,
  input  sfsx_pkg::byte_t     d_in,
  output sfsx_pkg::byte_t     q
);

  sfsx_pkg::byte_t byte_r;

  // Take the neighbor's byte on every accepted transfer.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_r <= d_in;
    end
  end

  assign q = byte_r;

endmodule

`default_nettype wire

@@ rtl/sfsx_window.sv @@
`default_nettype none

module sfsx_window (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [sfsx_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  sfsx_pkg::byte_t                     cfg_val,
  input  wire                                 in_valid,
  input  sfsx_pkg::byte_t                     in_byte,
  input  wire                                 emit_busy,
  output logic                                in_stall,
  output sfsx_pkg::capture_t                  cap,
  output sfsx_pkg::payload_t                  payload
);

  sfsx_pkg::byte_t start_r;
  sfsx_pkg::byte_t end_r;
  sfsx_pkg::byte_t tail_r;
  logic [sfsx_pkg::CNT_W-1:0] cnt_r;
  logic [sfsx_pkg::CNT_W-1:0] cnt_nxt;
  logic [sfsx_pkg::CNT_W-1:0] cnt_inc;

  sfsx_pkg::byte_t cell_q   [sfsx_pkg::FRAME_BYTES];
  sfsx_pkg::byte_t win_nxt  [sfsx_pkg::FRAME_BYTES];

  logic            accept;
  logic            cap_cond;
  sfsx_pkg::byte_t even_x;
  sfsx_pkg::byte_t odd_x;

  // Marker registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= sfsx_pkg::START_MARKER_RST;
      end_r   <= sfsx_pkg::END_MARKER_RST;
      tail_r  <= sfsx_pkg::TAIL_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sfsx_pkg::REG_START_MARKER: start_r <= cfg_val;
        sfsx_pkg::REG_END_MARKER:   end_r   <= cfg_val;
        sfsx_pkg::REG_TAIL_MARKER:  tail_r  <= cfg_val;
        default: ;
      endcase
    end
  end

  // Post-shift view of the window: each cell takes its newer neighbor,
  // the newest cell takes the incoming byte.
  always_comb begin
    for (int i = 0; i < sfsx_pkg::FRAME_BYTES - 1; i++) begin
      win_nxt[i] = cell_q[i+1];
    end
    win_nxt[sfsx_pkg::FRAME_BYTES-1] = in_byte;
  end

  // Row of byte cells, oldest at index zero.
  for (genvar g = 0; g < sfsx_pkg::FRAME_BYTES; g++) begin : g_cell
    sfsx_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .d_in     (win_nxt[g]),
      .q        (cell_q[g])
    );
  end

  // Saturating count of bytes since the last capture.
  always_comb begin
    if (cnt_r == sfsx_pkg::CNT_W'(sfsx_pkg::FRAME_BYTES)) begin
      cnt_inc = cnt_r;
    end else begin
      cnt_inc = cnt_r + 1'b1;
    end
  end

  assign cap_cond = (cnt_inc == sfsx_pkg::CNT_W'(sfsx_pkg::FRAME_BYTES))
                 && (win_nxt[0] == start_r)
                 && (in_byte == end_r);

  // A capture waits while the emitter still holds the previous frame.
  assign in_stall = emit_busy && cap_cond;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = cap_cond ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Frame check: XOR of even and odd payload bytes, plus the tail byte.
  always_comb begin
    even_x = '0;
    odd_x  = '0;
    for (int k = 0; k < sfsx_pkg::PAYLOAD_WORDS; k++) begin
      even_x = even_x ^ win_nxt[2*k];
      odd_x  = odd_x ^ win_nxt[2*k+1];
      payload[k] = {win_nxt[2*k+1], win_nxt[2*k]};
    end
  end

  assign cap.fire = accept && cap_cond;
  assign cap.good = (win_nxt[sfsx_pkg::FRAME_BYTES-2] == tail_r)
                 && (win_nxt[2*sfsx_pkg::PAYLOAD_WORDS] == even_x)
                 && (win_nxt[2*sfsx_pkg::PAYLOAD_WORDS+1] == odd_x);

endmodule

`default_nettype wire

@@ rtl/sfsx_emit.sv @@
`default_nettype none

module sfsx_emit (
  input  wire                            clk,
  input  wire                            rst_n,
  input  sfsx_pkg::capture_t             cap,
  input  sfsx_pkg::payload_t             payload,
  output logic                           busy,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic                           out_status,
  output logic [sfsx_pkg::IDX_W-1:0]     out_word_index,
  output sfsx_pkg::word_t                out_word_value,
  output logic                           out_last
);

  logic                          busy_r;
  logic                          good_r;
  logic [sfsx_pkg::IDX_W-1:0]    idx_r;
  sfsx_pkg::payload_t            words_r;

  logic                          out_valid_r;
  logic                          status_r;
  logic [sfsx_pkg::IDX_W-1:0]    oidx_r;
  sfsx_pkg::word_t               value_r;
  logic                          last_r;

  logic                          load;
  logic                          is_last;

  // Move the next word into the output register when it is free.
  assign load    = busy_r && (!out_valid_r || !out_stall);
  assign is_last = !good_r
                || (idx_r == sfsx_pkg::IDX_W'(sfsx_pkg::PAYLOAD_WORDS - 1));

  // Control state: frame in progress and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cap.fire) begin
        busy_r <= 1'b1;
      end else if (load && is_last) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Frame buffer: a word chain that shifts toward word zero on each load.
  always_ff @(posedge clk) begin
    if (cap.fire) begin
      good_r  <= cap.good;
      idx_r   <= '0;
      words_r <= payload;
    end else if (load) begin
      idx_r <= idx_r + 1'b1;
      for (int k = 0; k < sfsx_pkg::PAYLOAD_WORDS - 1; k++) begin
        words_r[k] <= words_r[k+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= good_r ? sfsx_pkg::STATUS_GOOD : sfsx_pkg::STATUS_BAD;
      oidx_r   <= good_r ? idx_r : '0;
      value_r  <= good_r ? words_r[0] : '0;
      last_r   <= is_last;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_word_index = oidx_r;
  assign out_word_value = value_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

@@ rtl/serial_frame_sync_xor_check.sv @@
// On the transfer of its end byte a frame enters the frame buffer, then the output register.
// One byte per cycle unless stalled; a good frame shifts out one word per cycle unless stalled.
// The input stalls only when a capturing byte arrives while the previous frame's words are
// still in the buffer, which takes a held output stage since frames are 24 bytes apart.
// Reset (rst_n, synchronous): markers return to 'S', LF, CR; byte count, busy and out_valid clear.
`default_nettype none

module serial_frame_sync_xor_check (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire [sfsx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire [sfsx_pkg::BYTE_W-1:0]         cfg_data,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire [sfsx_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_status,
  output logic [sfsx_pkg::IDX_W-1:0]         out_word_index,
  output logic [sfsx_pkg::WORD_W-1:0]        out_word_value,
  output logic                               out_last
);

  sfsx_pkg::capture_t cap;
  sfsx_pkg::payload_t payload;
  logic               emit_busy;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  sfsx_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .in_valid  (in_valid),
    .in_byte   (in_rx_byte),
    .emit_busy (emit_busy),
    .in_stall  (in_stall),
    .cap       (cap),
    .payload   (payload)
  );

  sfsx_emit u_emit (
    .clk            (clk),
    .rst_n          (rst_n),
    .cap            (cap),
    .payload        (payload),
    .busy           (emit_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_word_index (out_word_index),
    .out_word_value (out_word_value),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/sfsx_checker.sv @@
`default_nettype none

module sfsx_checker (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              out_valid,
  input wire                              out_stall,
  input wire                              out_status,
  input wire [sfsx_pkg::IDX_W-1:0]        out_word_index,
  input wire [sfsx_pkg::WORD_W-1:0]       out_word_value,
  input wire                              out_last
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_word_index) && $stable(out_word_value) && $stable(out_last))
    else $error("result changed while stalled");

  // A failed frame gives a single cleared result.
  a_bad_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sfsx_pkg::STATUS_BAD) |->
      out_last && (out_word_index == '0) && (out_word_value == '0))
    else $error("bad frame result malformed");

  // Word positions stay inside the payload and only the final one is last.
  a_good_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sfsx_pkg::STATUS_GOOD) |->
      (out_last == (out_word_index ==
        sfsx_pkg::IDX_W'(sfsx_pkg::PAYLOAD_WORDS - 1))))
    else $error("last flag does not match word position");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word_index <= sfsx_pkg::IDX_W'(sfsx_pkg::PAYLOAD_WORDS - 1)))
    else $error("word index out of range");

  // A transferred good word zero that is not last is followed directly by position one or no result.
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && (out_status == sfsx_pkg::STATUS_GOOD) && !out_last
      && out_word_index == '0 |=> !out_valid || (out_status == sfsx_pkg::STATUS_GOOD
      && out_word_index == sfsx_pkg::IDX_W'(1)))
    else $error("word sequence broken");

endmodule

bind serial_frame_sync_xor_check sfsx_checker u_sfsx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_word_index (out_word_index),
  .out_word_value (out_word_value),
  .out_last       (out_last)
);

`default_nettype wire
